// ----- hdl/i2r_pkg.sv -----
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and numeral tables for the integer to Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package i2r_pkg;

  // Field widths
  localparam int VALUE_W  = 12;
  localparam int SYMBOL_W = 7;

  // Largest value that can be written as a numeral
  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  // Greedy step table size
  localparam int NUM_STEPS  = 13;
  localparam int STEP_IDX_W = $clog2(NUM_STEPS);

  // Queue between the front and the back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // ASCII codes of the numeral letters
  localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
  localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
  localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
  localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
  localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
  localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
  localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
  localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

  // One classified item as held in the queue
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               oor;
  } item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_PAIR
  } back_state_t;

  // Value of each greedy step, largest first
  function automatic logic [VALUE_W-1:0] step_value(input logic [STEP_IDX_W-1:0] idx);
    logic [VALUE_W-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  // Leading letter of each step
  function automatic logic [SYMBOL_W-1:0] step_first(input logic [STEP_IDX_W-1:0] idx);
    logic [SYMBOL_W-1:0] s;
    case (idx)
      4'd0:    s = SYM_M;
      4'd1:    s = SYM_C;
      4'd2:    s = SYM_D;
      4'd3:    s = SYM_C;
      4'd4:    s = SYM_C;
      4'd5:    s = SYM_X;
      4'd6:    s = SYM_L;
      4'd7:    s = SYM_X;
      4'd8:    s = SYM_X;
      4'd9:    s = SYM_I;
      4'd10:   s = SYM_V;
      default: s = SYM_I;
    endcase
    return s;
  endfunction

  // Trailing letter of a subtractive pair, SYM_NONE for a single letter
  function automatic logic [SYMBOL_W-1:0] step_second(input logic [STEP_IDX_W-1:0] idx);
    logic [SYMBOL_W-1:0] s;
    case (idx)
      4'd1:    s = SYM_M;
      4'd3:    s = SYM_D;
      4'd5:    s = SYM_C;
      4'd7:    s = SYM_L;
      4'd9:    s = SYM_X;
      4'd11:   s = SYM_V;
      default: s = SYM_NONE;
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/i2r_front.sv -----
// ----------------------------------------------------------------------------
// i2r_front
// Accepts input values, flags those outside 1..3999 and pushes the
// classified item into the queue.
// ----------------------------------------------------------------------------
module i2r_front (
  input  logic                          start,
  output logic                          busy,
  input  logic [i2r_pkg::VALUE_W-1:0]   in_value,
  input  i2r_pkg::q_status_t            q_status,
  output logic                          push,
  output i2r_pkg::item_t                push_item
);

  // Stall the source while the queue has no room
  assign busy = q_status.full;
  assign push = start && !q_status.full;

  // Classify the value
  always_comb begin
    push_item.value = in_value;
    push_item.oor   = (in_value == '0) || (in_value > i2r_pkg::VALUE_MAX);
  end

endmodule

// ----- hdl/i2r_queue.sv -----
// ----------------------------------------------------------------------------
// i2r_queue
// Short first-in first-out queue of classified items between the front
// and the back.
// ----------------------------------------------------------------------------
module i2r_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  i2r_pkg::item_t       push_item,
  input  logic                 pop,
  output i2r_pkg::item_t       pop_item,
  output i2r_pkg::q_status_t   q_status
);

  i2r_pkg::item_t                  entry_r [i2r_pkg::QDEPTH];
  logic [i2r_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [i2r_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [i2r_pkg::QCNT_W-1:0]      count_r;
  logic                            do_push;
  logic                            do_pop;

  localparam logic [i2r_pkg::QPTR_W-1:0] PTR_LAST = i2r_pkg::QPTR_W'(i2r_pkg::QDEPTH - 1);
  localparam logic [i2r_pkg::QCNT_W-1:0] CNT_FULL = i2r_pkg::QCNT_W'(i2r_pkg::QDEPTH);
  localparam logic [i2r_pkg::QCNT_W-1:0] CNT_ONE  = i2r_pkg::QCNT_W'(1);

  assign q_status.full  = (count_r == CNT_FULL);
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_item       = entry_r[rd_ptr_r];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_ONE;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_ONE;
      end
    end
  end

  // Occupancy never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue occupancy above depth");

  // A push into a full queue would be lost
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full queue");

endmodule

// ----- hdl/i2r_back.sv -----
// ----------------------------------------------------------------------------
// i2r_back
// Pops classified items and emits the numeral one letter per cycle, taking
// the largest step that fits the remaining value each time.
// ----------------------------------------------------------------------------
module i2r_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  i2r_pkg::q_status_t             q_status,
  input  i2r_pkg::item_t                 pop_item,
  output logic                           pop,
  output logic                           out_valid,
  output logic [i2r_pkg::SYMBOL_W-1:0]   out_symbol,
  output logic                           out_is_last,
  output logic                           out_out_of_range
);

  i2r_pkg::back_state_t              state_r, state_nxt;
  logic [i2r_pkg::VALUE_W-1:0]       rest_r, rest_nxt;
  logic [i2r_pkg::SYMBOL_W-1:0]      second_r, second_nxt;
  logic                              valid_r, valid_nxt;
  logic [i2r_pkg::SYMBOL_W-1:0]      symbol_r, symbol_nxt;
  logic                              last_r, last_nxt;
  logic                              oor_r, oor_nxt;
  logic [i2r_pkg::STEP_IDX_W-1:0]    pick;
  logic [i2r_pkg::VALUE_W-1:0]       rest_sub;
  logic [i2r_pkg::SYMBOL_W-1:0]      pick_second;

  // Pick the largest step not above the remaining value
  always_comb begin
    pick = i2r_pkg::STEP_IDX_W'(i2r_pkg::NUM_STEPS - 1);
    for (int i = i2r_pkg::NUM_STEPS - 1; i >= 0; i--) begin
      if (rest_r >= i2r_pkg::step_value(i2r_pkg::STEP_IDX_W'(i))) begin
        pick = i2r_pkg::STEP_IDX_W'(i);
      end
    end
  end

  assign rest_sub    = rest_r - i2r_pkg::step_value(pick);
  assign pick_second = i2r_pkg::step_second(pick);

  // Sequencer: next state and result
  always_comb begin
    state_nxt  = state_r;
    rest_nxt   = rest_r;
    second_nxt = second_r;
    valid_nxt  = 1'b0;
    symbol_nxt = i2r_pkg::SYM_NONE;
    last_nxt   = 1'b0;
    oor_nxt    = 1'b0;
    pop        = 1'b0;
    case (state_r)
      i2r_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          if (pop_item.oor) begin
            valid_nxt = 1'b1;
            last_nxt  = 1'b1;
            oor_nxt   = 1'b1;
          end else begin
            rest_nxt  = pop_item.value;
            state_nxt = i2r_pkg::BK_EMIT;
          end
        end
      end
      i2r_pkg::BK_EMIT: begin
        valid_nxt  = 1'b1;
        symbol_nxt = i2r_pkg::step_first(pick);
        rest_nxt   = rest_sub;
        if (pick_second != i2r_pkg::SYM_NONE) begin
          second_nxt = pick_second;
          state_nxt  = i2r_pkg::BK_PAIR;
        end else if (rest_sub == '0) begin
          last_nxt  = 1'b1;
          state_nxt = i2r_pkg::BK_IDLE;
        end
      end
      i2r_pkg::BK_PAIR: begin
        valid_nxt  = 1'b1;
        symbol_nxt = second_r;
        if (rest_r == '0) begin
          last_nxt  = 1'b1;
          state_nxt = i2r_pkg::BK_IDLE;
        end else begin
          state_nxt = i2r_pkg::BK_EMIT;
        end
      end
      default: begin
        state_nxt = i2r_pkg::BK_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2r_pkg::BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Hold working value and result payload
  always_ff @(posedge clk) begin
    rest_r   <= rest_nxt;
    second_r <= second_nxt;
    symbol_r <= symbol_nxt;
    last_r   <= last_nxt;
    oor_r    <= oor_nxt;
  end

  assign out_valid        = valid_r;
  assign out_symbol       = symbol_r;
  assign out_is_last      = last_r;
  assign out_out_of_range = oor_r;

  // An out-of-range result is a lone, letterless, final result
  a_oor_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_is_last && out_symbol == i2r_pkg::SYM_NONE))
    else $error("malformed out-of-range result");

  // The second letter of a pair follows a non-final first letter
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == i2r_pkg::BK_PAIR) |-> (out_valid && !out_is_last && !out_out_of_range))
    else $error("pair letter without leading letter");

  // A run ends only when the remaining value is used up
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last && !out_out_of_range) |-> (rest_r == '0))
    else $error("run ended with value left over");

endmodule

// ----- hdl/integer_to_roman_encoder.sv -----
// ----------------------------------------------------------------------------
// integer_to_roman_encoder
// Converts a 12-bit integer to its Roman numeral, one ASCII letter per
// output strobe, most significant letter first.
// ----------------------------------------------------------------------------
// Flow: with the back end idle, an accepted value is written into the queue,
//   popped and loaded by the back end, and its first letter is then registered
//   onto the outputs; an out-of-range result is registered straight from the
//   load. The back end finishes one item before it pops another; a two-entry
//   queue lets further items be accepted meanwhile until it fills.
// Reset: synchronous, active low; clears the queue and the sequencer.
module integer_to_roman_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [i2r_pkg::VALUE_W-1:0]    in_value,
  output logic                           out_valid,
  output logic [i2r_pkg::SYMBOL_W-1:0]   out_symbol,
  output logic                           out_is_last,
  output logic                           out_out_of_range
);

  i2r_pkg::q_status_t q_status;
  i2r_pkg::item_t     push_item;
  i2r_pkg::item_t     pop_item;
  logic               push;
  logic               pop;

  // Accept and classify
  i2r_front u_front (
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Buffer classified items
  i2r_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  // Emit letters
  i2r_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .pop_item         (pop_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_symbol       (out_symbol),
    .out_is_last      (out_is_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule
